@@ hw/rtl/twc_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle wave channel package
// Shared event codes, register offsets, result type and lookup tables.
// ----------------------------------------------------------------------------
package twc_pkg;

   localparam int ActionWidth = 3;
   localparam int IndexWidth  = 2;
   localparam int DataWidth   = 8;
   localparam int LevelWidth  = 4;

   typedef enum logic [ActionWidth-1:0] {
      ACT_WRITE   = 3'd0,
      ACT_ENABLE  = 3'd1,
      ACT_TIMER   = 3'd2,
      ACT_QUARTER = 3'd3,
      ACT_HALF    = 3'd4
   } action_type;

   localparam logic [IndexWidth-1:0] REG_LINEAR   = 2'd0;
   localparam logic [IndexWidth-1:0] REG_UNUSED   = 2'd1;
   localparam logic [IndexWidth-1:0] REG_TIMER_LO = 2'd2;
   localparam logic [IndexWidth-1:0] REG_TIMER_HI = 2'd3;

   typedef struct packed {
      logic [LevelWidth-1:0] level;
      logic                  length_nonzero;
   } result_type;

   // The level falls from 15 to 0 over the first half and rises back after.
   function automatic logic [LevelWidth-1:0] level_lookup(input logic [4:0] step);
      level_lookup = step[4] ? step[3:0] : ~step[3:0];
   endfunction

   function automatic logic [7:0] length_lookup(input logic [4:0] idx);
      logic [7:0] value;
      case (idx)
         5'd0:  value = 8'd10;
         5'd1:  value = 8'd254;
         5'd2:  value = 8'd20;
         5'd3:  value = 8'd2;
         5'd4:  value = 8'd40;
         5'd5:  value = 8'd4;
         5'd6:  value = 8'd80;
         5'd7:  value = 8'd6;
         5'd8:  value = 8'd160;
         5'd9:  value = 8'd8;
         5'd10: value = 8'd60;
         5'd11: value = 8'd10;
         5'd12: value = 8'd14;
         5'd13: value = 8'd12;
         5'd14: value = 8'd26;
         5'd15: value = 8'd14;
         5'd16: value = 8'd12;
         5'd17: value = 8'd16;
         5'd18: value = 8'd24;
         5'd19: value = 8'd18;
         5'd20: value = 8'd48;
         5'd21: value = 8'd20;
         5'd22: value = 8'd96;
         5'd23: value = 8'd22;
         5'd24: value = 8'd192;
         5'd25: value = 8'd24;
         5'd26: value = 8'd72;
         5'd27: value = 8'd26;
         5'd28: value = 8'd16;
         5'd29: value = 8'd28;
         5'd30: value = 8'd32;
         5'd31: value = 8'd30;
         default: value = 8'd0;
      endcase
      length_lookup = value;
   endfunction

endpackage

@@ hw/rtl/twc_req_if.sv @@
// ----------------------------------------------------------------------------
// Triangle wave channel request interface
// Valid/ready channel that carries one channel event per request.
// ----------------------------------------------------------------------------
interface twc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [1:0] reg_index;
   logic [7:0] write_data;
   logic       enable_value;

   modport source (output valid, action, reg_index, write_data, enable_value,
                   input ready);
   modport sink   (input valid, action, reg_index, write_data, enable_value,
                   output ready);
endinterface

@@ hw/rtl/twc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Triangle wave channel response interface
// Valid/ready channel that carries the level and length status.
// ----------------------------------------------------------------------------
interface twc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] level;
   logic       length_nonzero;

   modport source (output valid, level, length_nonzero, input ready);
   modport sink   (input valid, level, length_nonzero, output ready);
endinterface

@@ hw/rtl/triangle_wave_channel.sv @@
// ----------------------------------------------------------------------------
// Triangle wave channel
// Triangle sound channel with timer, sequencer, linear and length counters.
// ----------------------------------------------------------------------------
// Each accepted request's result is registered as the next cycle's response.
// One request per cycle unless a response stalls; all state updates on accept.
// A request is taken whenever the result register is empty or being read.
// Synchronous reset clears all channel state and the result valid flag.
module triangle_wave_channel (
   input logic      clock,
   input logic      reset,
   twc_req_if.sink  req_chan,
   twc_rsp_if.source rsp_chan
);
   import twc_pkg::*;

   logic       req_accept;
   logic       rsp_take;
   logic       out_valid;
   result_type next_result;
   result_type out_result;

   assign rsp_take       = out_valid & rsp_chan.ready;
   assign req_chan.ready = !out_valid || rsp_chan.ready;
   assign req_accept     = req_chan.valid & req_chan.ready;

   twc_state u_state (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .action       (req_chan.action),
      .reg_index    (req_chan.reg_index),
      .write_data   (req_chan.write_data),
      .enable_value (req_chan.enable_value),
      .result       (next_result)
   );

   twc_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .result_in (next_result),
      .take      (rsp_take),
      .valid     (out_valid),
      .result    (out_result)
   );

   assign rsp_chan.valid          = out_valid;
   assign rsp_chan.level          = out_result.level;
   assign rsp_chan.length_nonzero = out_result.length_nonzero;

   property p_accept_gives_rsp;
      @(posedge clock) disable iff (reset) req_accept |=> rsp_chan.valid;
   endproperty
   assert property (p_accept_gives_rsp)
      else $error("accepted request produced no response");

   property p_no_accept_when_full;
      @(posedge clock) disable iff (reset)
         (out_valid && !rsp_chan.ready) |-> !req_chan.ready;
   endproperty
   assert property (p_no_accept_when_full)
      else $error("request accepted while a response is pending");

   property p_disable_clears_length;
      @(posedge clock) disable iff (reset)
         (req_accept && req_chan.action == ACT_ENABLE && !req_chan.enable_value)
            |=> !rsp_chan.length_nonzero;
   endproperty
   assert property (p_disable_clears_length)
      else $error("disable did not clear the length counter");

endmodule

@@ hw/rtl/twc_state.sv @@
// ----------------------------------------------------------------------------
// Triangle wave channel state
// Timer, sequencer, linear and length counters, updated once per request.
// ----------------------------------------------------------------------------
module twc_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [2:0]            action,
   input  logic [1:0]            reg_index,
   input  logic [7:0]            write_data,
   input  logic                  enable_value,
   output twc_pkg::result_type   result
);
   import twc_pkg::*;

   logic [10:0] timer_period_ff, timer_period_in;
   logic [10:0] timer_count_ff,  timer_count_in;
   logic [4:0]  step_pointer_ff, step_pointer_in;
   logic [6:0]  linear_count_ff, linear_count_in;
   logic [6:0]  linear_reload_ff, linear_reload_in;
   logic        reload_flag_ff,  reload_flag_in;
   logic        halt_ff,         halt_in;
   logic [7:0]  length_count_ff, length_count_in;
   logic        enabled_ff,      enabled_in;
   logic [6:0]  linear_clocked;
   logic        reload_clocked;

   always_comb begin
      linear_clocked = linear_count_ff;
      if (reload_flag_ff) begin
         linear_clocked = linear_reload_ff;
      end else if (linear_count_ff != 7'd0) begin
         linear_clocked = linear_count_ff - 7'd1;
      end
      reload_clocked = reload_flag_ff & halt_ff;
   end

   always_comb begin
      timer_period_in  = timer_period_ff;
      timer_count_in   = timer_count_ff;
      step_pointer_in  = step_pointer_ff;
      linear_count_in  = linear_count_ff;
      linear_reload_in = linear_reload_ff;
      reload_flag_in   = reload_flag_ff;
      halt_in          = halt_ff;
      length_count_in  = length_count_ff;
      enabled_in       = enabled_ff;
      if (accept) begin
         case (action)
            ACT_WRITE: begin
               case (reg_index)
                  REG_LINEAR: begin
                     linear_reload_in = write_data[6:0];
                     halt_in          = write_data[7];
                  end
                  REG_TIMER_LO: begin
                     timer_period_in = {timer_period_ff[10:8], write_data};
                  end
                  REG_TIMER_HI: begin
                     timer_period_in = {write_data[2:0], timer_period_ff[7:0]};
                     if (enabled_ff) begin
                        length_count_in = length_lookup(write_data[7:3]);
                     end
                     reload_flag_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
            ACT_ENABLE: begin
               enabled_in = enable_value;
               if (!enable_value) begin
                  length_count_in = 8'd0;
               end
            end
            ACT_TIMER: begin
               if (timer_count_ff != 11'd0) begin
                  timer_count_in = timer_count_ff - 11'd1;
               end else begin
                  timer_count_in = timer_period_ff;
                  if (length_count_ff != 8'd0 && linear_count_ff != 7'd0) begin
                     step_pointer_in = step_pointer_ff + 5'd1;
                  end
               end
            end
            ACT_QUARTER: begin
               linear_count_in = linear_clocked;
               reload_flag_in  = reload_clocked;
            end
            ACT_HALF: begin
               linear_count_in = linear_clocked;
               reload_flag_in  = reload_clocked;
               if (!halt_ff && length_count_ff != 8'd0) begin
                  length_count_in = length_count_ff - 8'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_period_ff  <= '0;
         timer_count_ff   <= '0;
         step_pointer_ff  <= '0;
         linear_count_ff  <= '0;
         linear_reload_ff <= '0;
         reload_flag_ff   <= 1'b0;
         halt_ff          <= 1'b0;
         length_count_ff  <= '0;
         enabled_ff       <= 1'b0;
      end else begin
         timer_period_ff  <= timer_period_in;
         timer_count_ff   <= timer_count_in;
         step_pointer_ff  <= step_pointer_in;
         linear_count_ff  <= linear_count_in;
         linear_reload_ff <= linear_reload_in;
         reload_flag_ff   <= reload_flag_in;
         halt_ff          <= halt_in;
         length_count_ff  <= length_count_in;
         enabled_ff       <= enabled_in;
      end
   end

   assign result.level          = level_lookup(step_pointer_in);
   assign result.length_nonzero = (length_count_in != 8'd0);

endmodule

@@ hw/rtl/twc_out.sv @@
// ----------------------------------------------------------------------------
// Triangle wave channel result register
// Holds one result until the response side takes it.
// ----------------------------------------------------------------------------
module twc_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  twc_pkg::result_type result_in,
   input  logic                take,
   output logic                valid,
   output twc_pkg::result_type result
);
   import twc_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in_d;

   always_comb begin
      valid_in    = valid_ff;
      result_in_d = result_ff;
      if (load) begin
         valid_in    = 1'b1;
         result_in_d = result_in;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in_d;
   end

   assign valid  = valid_ff;
   assign result = result_ff;

endmodule

@@ tb/sv/triangle_wave_channel_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle wave channel testbench
// Sends channel events through the request channel with bursty timing and a
// stalling receiver, predicts each level and length status, and checks every
// response in order against the prediction.
// ----------------------------------------------------------------------------
module triangle_wave_channel_tb;
   import twc_pkg::*;

   localparam int SegmentCount   = 5;
   localparam int SegmentLength  = 305;
   localparam int HoldOffLength  = 160;
   localparam int IdleLimit      = 2000;

   typedef struct {
      logic [2:0] action;
      logic [1:0] reg_index;
      logic [7:0] write_data;
      logic       enable_value;
      bit         drain;
   } channel_request_type;

   logic clock;
   logic reset;

   twc_req_if req_chan ();
   twc_rsp_if rsp_chan ();

   triangle_wave_channel u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [7:0] length_table [32] = '{
      8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
   };

   logic [10:0] tmr_period;
   logic [10:0] tmr_count;
   logic [4:0]  step_idx;
   logic [6:0]  lin_count;
   logic [6:0]  lin_reload;
   logic        lin_reload_pending;
   logic        halt_flag;
   logic [7:0]  len_count;
   logic        chan_on;

   channel_request_type event_queue[$];
   result_type          level_queue[$];
   bit                  next_drain;
   int                  mismatch_count;
   int                  idle_cycles;
   logic                req_taken;

   int burst_left;
   int gap_left;
   int rx_cycle;
   int rx_hold_left;
   int rx_mode;
   int rx_mode_left;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clock_linear_counter();
      if (lin_reload_pending)
         lin_count = lin_reload;
      else if (lin_count != 7'd0)
         lin_count = lin_count - 7'd1;
      if (!halt_flag)
         lin_reload_pending = 1'b0;
   endfunction

   function automatic result_type apply_event(channel_request_type ev);
      result_type r;
      case (ev.action)
         ACT_WRITE: begin
            case (ev.reg_index)
               REG_LINEAR: begin
                  lin_reload = ev.write_data[6:0];
                  halt_flag  = ev.write_data[7];
               end
               REG_TIMER_LO: tmr_period[7:0] = ev.write_data;
               REG_TIMER_HI: begin
                  tmr_period[10:8] = ev.write_data[2:0];
                  if (chan_on)
                     len_count = length_table[ev.write_data[7:3]];
                  lin_reload_pending = 1'b1;
               end
               default: ;
            endcase
         end
         ACT_ENABLE: begin
            chan_on = ev.enable_value;
            if (!chan_on)
               len_count = 8'd0;
         end
         ACT_TIMER: begin
            if (tmr_count != 11'd0) begin
               tmr_count = tmr_count - 11'd1;
            end else begin
               tmr_count = tmr_period;
               if (len_count != 8'd0 && lin_count != 7'd0)
                  step_idx = step_idx + 5'd1;
            end
         end
         ACT_QUARTER: clock_linear_counter();
         ACT_HALF: begin
            clock_linear_counter();
            if (!halt_flag && len_count != 8'd0)
               len_count = len_count - 8'd1;
         end
         default: ;
      endcase
      r.level          = step_idx[4] ? step_idx[3:0] : 4'd15 - step_idx[3:0];
      r.length_nonzero = (len_count != 8'd0);
      return r;
   endfunction

   function automatic void push_request(logic [2:0] action, logic [1:0] reg_index,
                                        logic [7:0] write_data, logic enable_value);
      channel_request_type ev;
      ev.action       = action;
      ev.reg_index    = reg_index;
      ev.write_data   = write_data;
      ev.enable_value = enable_value;
      ev.drain        = next_drain;
      next_drain      = 1'b0;
      event_queue.push_back(ev);
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      channel_request_type nxt;
      logic                offer;
      if (reset) begin
         req_chan.valid <= 1'b0;
         burst_left     = $urandom_range(1, 24);
         gap_left       = 0;
      end else if (!req_chan.valid || req_taken) begin
         offer = 1'b0;
         if (gap_left != 0) begin
            gap_left = gap_left - 1;
         end else if (event_queue.size() != 0 &&
                      !(event_queue[0].drain && level_queue.size() != 0)) begin
            nxt   = event_queue.pop_front();
            offer = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end
         req_chan.valid <= offer;
         if (offer) begin
            req_chan.action       <= nxt.action;
            req_chan.reg_index    <= nxt.reg_index;
            req_chan.write_data   <= nxt.write_data;
            req_chan.enable_value <= nxt.enable_value;
         end
      end
   end

   // Response receiver: changing stall patterns plus long hold-offs.
   always @(negedge clock) begin
      logic ready_next;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_cycle       = 0;
         rx_hold_left   = 0;
         rx_mode        = 0;
         rx_mode_left   = 0;
      end else begin
         rx_cycle = rx_cycle + 1;
         if (rx_cycle == 700 || rx_cycle == 3000)
            rx_hold_left = HoldOffLength;
         if (rx_hold_left != 0) begin
            rx_hold_left = rx_hold_left - 1;
            ready_next   = 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = $urandom_range(0, 3);
               rx_mode_left = $urandom_range(20, 120);
            end else begin
               rx_mode_left = rx_mode_left - 1;
            end
            case (rx_mode)
               0: ready_next = 1'b1;
               1: ready_next = 1'($urandom_range(0, 1));
               2: ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_chan.ready <= ready_next;
      end
   end

   // Monitor: checks responses first, then predicts the newly accepted request.
   always @(posedge clock) begin
      result_type          want;
      channel_request_type ev;
      if (reset) begin
         req_taken   <= 1'b0;
         idle_cycles = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (level_queue.size() == 0) begin
               $display("%0t: response with no request waiting: level %0d status %0b",
                        $time, rsp_chan.level, rsp_chan.length_nonzero);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = level_queue.pop_front();
               if (rsp_chan.level !== want.level) begin
                  $display("%0t: level expected %0d actual %0d",
                           $time, want.level, rsp_chan.level);
                  mismatch_count = mismatch_count + 1;
               end
               if (rsp_chan.length_nonzero !== want.length_nonzero) begin
                  $display("%0t: length_nonzero expected %0b actual %0b",
                           $time, want.length_nonzero, rsp_chan.length_nonzero);
                  mismatch_count = mismatch_count + 1;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            ev.action       = req_chan.action;
            ev.reg_index    = req_chan.reg_index;
            ev.write_data   = req_chan.write_data;
            ev.enable_value = req_chan.enable_value;
            ev.drain        = 1'b0;
            level_queue.push_back(apply_event(ev));
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles = idle_cycles + 1;
         req_taken <= req_chan.valid && req_chan.ready;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= IdleLimit) begin
         $display("triangle_wave_channel regression: fail");
         $finish;
      end
   end

   initial begin
      int          pick;
      logic [1:0]  idx;
      logic [7:0]  data;
      clock                 = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.action       = ACT_WRITE;
      req_chan.reg_index    = REG_LINEAR;
      req_chan.write_data   = 8'd0;
      req_chan.enable_value = 1'b0;
      rsp_chan.ready        = 1'b0;
      mismatch_count        = 0;
      next_drain            = 1'b0;
      tmr_period            = 11'd0;
      tmr_count             = 11'd0;
      step_idx              = 5'd0;
      lin_count             = 7'd0;
      lin_reload            = 7'd0;
      lin_reload_pending    = 1'b0;
      halt_flag             = 1'b0;
      len_count             = 8'd0;
      chan_on               = 1'b0;

      // Directed events: idle counters, length load while disabled, unused
      // register, halt behavior, full-range period, unknown actions, disable.
      push_request(ACT_HALF, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_TIMER, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_WRITE, REG_TIMER_HI, 8'hFF, 1'b0);
      push_request(ACT_ENABLE, REG_LINEAR, 8'h00, 1'b1);
      push_request(ACT_WRITE, REG_LINEAR, 8'h05, 1'b0);
      push_request(ACT_WRITE, REG_TIMER_LO, 8'h00, 1'b0);
      push_request(ACT_WRITE, REG_TIMER_HI, 8'h08, 1'b0);
      push_request(ACT_WRITE, REG_UNUSED, 8'hFF, 1'b1);
      push_request(ACT_QUARTER, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_TIMER, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_TIMER, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_HALF, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_WRITE, REG_LINEAR, 8'hFF, 1'b0);
      push_request(ACT_WRITE, REG_TIMER_HI, 8'hFF, 1'b0);
      push_request(ACT_QUARTER, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_HALF, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_WRITE, REG_TIMER_LO, 8'hFF, 1'b0);
      push_request(ACT_TIMER, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_TIMER, REG_LINEAR, 8'h00, 1'b0);
      push_request(3'd5, REG_TIMER_HI, 8'hFF, 1'b1);
      push_request(3'd7, REG_TIMER_HI, 8'hFF, 1'b1);
      push_request(ACT_ENABLE, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_ENABLE, REG_LINEAR, 8'h00, 1'b1);
      push_request(ACT_WRITE, REG_LINEAR, 8'h00, 1'b0);
      push_request(ACT_WRITE, REG_TIMER_HI, 8'h18, 1'b0);

      for (int s = 0; s < SegmentCount; s++) begin
         next_drain = 1'b1;
         for (int n = 0; n < SegmentLength; n++) begin
            pick = $urandom_range(0, 99);
            idx  = 2'($urandom_range(0, 3));
            data = 8'($urandom_range(0, 255));
            if (pick < 52) begin
               push_request(ACT_TIMER, idx, data, 1'($urandom_range(0, 1)));
            end else if (pick < 62) begin
               push_request(ACT_QUARTER, idx, data, 1'($urandom_range(0, 1)));
            end else if (pick < 68) begin
               push_request(ACT_HALF, idx, data, 1'($urandom_range(0, 1)));
            end else if (pick < 88) begin
               if (idx == REG_TIMER_LO && $urandom_range(0, 3) != 0)
                  data = 8'($urandom_range(0, 6));
               if (idx == REG_TIMER_HI && $urandom_range(0, 3) != 0)
                  data[2:0] = 3'd0;
               push_request(ACT_WRITE, idx, data, 1'($urandom_range(0, 1)));
            end else if (pick < 97) begin
               push_request(ACT_ENABLE, idx, data, $urandom_range(0, 7) != 0);
            end else begin
               push_request(3'($urandom_range(5, 7)), idx, data,
                            1'($urandom_range(0, 1)));
            end
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (event_queue.size() != 0 || req_chan.valid)
         @(negedge clock);
      while (level_queue.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);

      if (mismatch_count == 0)
         $display("triangle_wave_channel regression: pass");
      else
         $display("triangle_wave_channel regression: fail");
      $finish;
   end

endmodule
